FILE: design/poi_pkg.sv
`timescale 1ns / 1ps
package poi_pkg;

    localparam int unsigned DT_ANGLE_K  = 32'd2867080570;
    localparam int          CORDIC_GAIN = 652032874;
    localparam int unsigned DIST_DIV    = 1000000;
    // ceil(2^68 / 15625); exact floor(n / 15625) for n <= 2^56
    localparam logic [54:0] DIST_RECIP  = 55'd18889465931478581;

    typedef enum logic [4:0] {
        S_IDLE, S_MULW, S_MULV, S_Q0, S_Q1, S_Q2, S_Q3, S_KLO, S_KHI, S_HEAD,
        S_C1INIT, S_C1STEP, S_C1END, S_C2INIT, S_C2STEP, S_C2END,
        S_XA, S_XB, S_XUPD, S_YA, S_YB, S_YUPD, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_LOAD, CMD_MULW, CMD_MULV, CMD_Q0, CMD_Q1, CMD_Q2, CMD_Q3,
        CMD_KLO, CMD_KHI, CMD_HEAD,
        CMD_COR_INIT, CMD_COR_STEP, CMD_COR1_END, CMD_COR2_END,
        CMD_XA, CMD_XB, CMD_XUPD, CMD_YA, CMD_YB, CMD_YUPD, CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic cor_last;
        logic out_busy;
    } t_status;

    function automatic logic [31:0] atan_lut(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;  5'd31: v = 32'h00000000;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: design/poi_ctrl.sv
`timescale 1ns / 1ps
module poi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    input  poi_pkg::t_status i_status,
    output logic             o_s_axis_tready,
    output poi_pkg::t_cmd    o_cmd
);
    import poi_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = CMD_NOP;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = i_rst_n;
                if (i_rst_n && i_s_axis_tvalid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_MULW;
                end
            end
            S_MULW:   begin o_cmd = CMD_MULW;     n_state = S_MULV;   end
            S_MULV:   begin o_cmd = CMD_MULV;     n_state = S_Q0;     end
            S_Q0:     begin o_cmd = CMD_Q0;       n_state = S_Q1;     end
            S_Q1:     begin o_cmd = CMD_Q1;       n_state = S_Q2;     end
            S_Q2:     begin o_cmd = CMD_Q2;       n_state = S_Q3;     end
            S_Q3:     begin o_cmd = CMD_Q3;       n_state = S_KLO;    end
            S_KLO:    begin o_cmd = CMD_KLO;      n_state = S_KHI;    end
            S_KHI:    begin o_cmd = CMD_KHI;      n_state = S_HEAD;   end
            S_HEAD:   begin o_cmd = CMD_HEAD;     n_state = S_C1INIT; end
            S_C1INIT: begin o_cmd = CMD_COR_INIT; n_state = S_C1STEP; end
            S_C1STEP: begin
                o_cmd = CMD_COR_STEP;
                if (i_status.cor_last) n_state = S_C1END;
            end
            S_C1END:  begin o_cmd = CMD_COR1_END; n_state = S_C2INIT; end
            S_C2INIT: begin o_cmd = CMD_COR_INIT; n_state = S_C2STEP; end
            S_C2STEP: begin
                o_cmd = CMD_COR_STEP;
                if (i_status.cor_last) n_state = S_C2END;
            end
            S_C2END:  begin o_cmd = CMD_COR2_END; n_state = S_XA; end
            S_XA:     begin o_cmd = CMD_XA;   n_state = S_XB;   end
            S_XB:     begin o_cmd = CMD_XB;   n_state = S_XUPD; end
            S_XUPD:   begin o_cmd = CMD_XUPD; n_state = S_YA;   end
            S_YA:     begin o_cmd = CMD_YA;   n_state = S_YB;   end
            S_YB:     begin o_cmd = CMD_YB;   n_state = S_YUPD; end
            S_YUPD:   begin o_cmd = CMD_YUPD; n_state = S_DONE; end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd   = CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: design/poi_datapath.sv
`timescale 1ns / 1ps
module poi_datapath #(
    parameter int CORDIC_STEPS = 24,
    parameter int FRAC_BITS    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  poi_pkg::t_cmd     i_cmd,
    output poi_pkg::t_status  o_status,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic [111:0]      i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [255:0]      o_m_axis_tdata,
    output logic              o_m_axis_tuser
);
    import poi_pkg::*;

    localparam int SH = 22 + FRAC_BITS;
    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] C_LAST = CW'(CORDIC_STEPS - 1);
    localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] POS_MIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;

    logic               r_mode, r_mode_used;
    logic [47:0]        r_prev;
    logic signed [47:0] r_x, r_y;
    logic [31:0]        r_head;
    logic [31:0]        r_vin, r_win;
    logic [31:0]        r_dtm;
    logic               r_dtneg;
    logic [63:0]        r_am, r_plo, r_phi, r_pa, r_pb;
    logic [31:0]        r_dth, r_cang;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_cflip;
    logic [CW-1:0]      r_ci;
    logic signed [31:0] r_c1, r_s1, r_qz, r_qw;
    logic [62:0]        r_dq;
    logic [63:0]        r_qacc;
    logic               r_out_valid;
    logic [255:0]       r_out_data;
    logic               r_out_user;

    // shared 32x32 multiplier
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;
    logic [31:0] w_vmag, w_wmag, w_c1mag, w_s1mag;
    logic [42:0] w_dm;
    logic [27:0] w_nlo;
    logic [28:0] w_nhi;

    assign w_vmag  = r_vin[31] ? (32'd0 - r_vin) : r_vin;
    assign w_wmag  = r_win[31] ? (32'd0 - r_win) : r_win;
    assign w_c1mag = r_c1[31] ? (32'd0 - 32'(r_c1)) : 32'(r_c1);
    assign w_s1mag = r_s1[31] ? (32'd0 - 32'(r_s1)) : 32'(r_s1);
    // |v*dt| / 10^6 = ((|v*dt| >> 6) * DIST_RECIP) >> 68
    assign w_nlo   = r_dq[33:6];
    assign w_nhi   = r_dq[62:34];
    assign w_dm    = r_qacc[54:12];

    always_comb begin
        w_mul_a = 32'd0;
        w_mul_b = 32'd0;
        unique case (i_cmd)
            CMD_MULW: begin w_mul_a = w_wmag;         w_mul_b = r_dtm;      end
            CMD_MULV: begin w_mul_a = w_vmag;         w_mul_b = r_dtm;      end
            CMD_Q0:   begin w_mul_a = 32'(w_nlo); w_mul_b = 32'(DIST_RECIP[27:0]);  end
            CMD_Q1:   begin w_mul_a = 32'(w_nlo); w_mul_b = 32'(DIST_RECIP[54:28]); end
            CMD_Q2:   begin w_mul_a = 32'(w_nhi); w_mul_b = 32'(DIST_RECIP[27:0]);  end
            CMD_Q3:   begin w_mul_a = 32'(w_nhi); w_mul_b = 32'(DIST_RECIP[54:28]); end
            CMD_KLO:  begin w_mul_a = r_am[31:0];     w_mul_b = DT_ANGLE_K; end
            CMD_KHI:  begin w_mul_a = r_am[63:32];    w_mul_b = DT_ANGLE_K; end
            CMD_XA:   begin w_mul_a = 32'(w_dm[42:21]); w_mul_b = w_c1mag;  end
            CMD_XB:   begin w_mul_a = 32'(w_dm[20:0]);  w_mul_b = w_c1mag;  end
            CMD_YA:   begin w_mul_a = 32'(w_dm[42:21]); w_mul_b = w_s1mag;  end
            CMD_YB:   begin w_mul_a = 32'(w_dm[20:0]);  w_mul_b = w_s1mag;  end
            default:  begin w_mul_a = 32'd0;          w_mul_b = 32'd0;      end
        endcase
    end

    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    // step interval
    logic [47:0]        w_ts;
    logic signed [48:0] w_diff;
    logic signed [31:0] w_dt;

    assign w_ts   = i_s_axis_tdata[47:0];
    assign w_diff = $signed({1'b0, w_ts}) - $signed({1'b0, r_prev});

    always_comb begin
        if (r_prev == 48'd0) begin
            w_dt = 32'sd0;
        end else if (w_diff < -49'sd2147483648) begin
            w_dt = 32'sh8000_0000;
        end else if (w_diff > 49'sd2147483647) begin
            w_dt = 32'sh7FFF_FFFF;
        end else begin
            w_dt = w_diff[31:0];
        end
    end

    // heading change
    logic [95:0] w_pk;
    logic [32:0] w_r33;
    logic        w_aneg, w_dneg;
    logic [31:0] w_dth, w_half, w_head_new;

    assign w_pk       = {r_phi, 32'd0} + {32'd0, r_plo};
    assign w_r33      = w_pk[SH+32:SH];
    assign w_aneg     = r_win[31] ^ r_dtneg;
    assign w_dneg     = r_vin[31] ^ r_dtneg;
    assign w_dth      = w_aneg ? (32'd0 - w_r33[31:0]) : w_r33[31:0];
    assign w_half     = w_aneg ? (32'd0 - w_r33[32:1]) : w_r33[32:1];
    assign w_head_new = r_head + r_dth;

    // CORDIC
    logic signed [33:0] w_z0, w_xs, w_ys, w_at;
    logic [4:0]         w_k;
    logic signed [31:0] w_cfin, w_sfin;

    assign w_z0 = 34'(signed'(r_cang));
    assign w_k  = 5'(r_ci);
    assign w_xs = r_cx >>> w_k;
    assign w_ys = r_cy >>> w_k;
    assign w_at = $signed({2'b00, atan_lut(w_k)});

    function automatic logic signed [31:0] cfin(input logic signed [33:0] v,
                                               input logic flip);
        logic signed [31:0] c;
        if (v > 34'sd1073741824) begin
            c = 32'sd1073741824;
        end else if (v < -34'sd1073741824) begin
            c = -32'sd1073741824;
        end else begin
            c = v[31:0];
        end
        return flip ? -c : c;
    endfunction

    assign w_cfin = cfin(r_cx, r_cflip);
    assign w_sfin = cfin(r_cy, r_cflip);

    // position update
    logic [73:0]        w_dsum;
    logic [43:0]        w_dmag;
    logic signed [49:0] w_dpos, w_npos;
    logic signed [47:0] w_pos_sel, w_pos_sat;
    logic               w_cneg;

    assign w_dsum    = {r_pa[52:0], 21'd0} + 74'(r_pb);
    assign w_dmag    = w_dsum[73:30];
    assign w_cneg    = (i_cmd == CMD_XUPD) ? r_c1[31] : r_s1[31];
    assign w_dpos    = (w_dneg ^ w_cneg) ? -$signed({6'd0, w_dmag}) : $signed({6'd0, w_dmag});
    assign w_pos_sel = (i_cmd == CMD_XUPD) ? r_x : r_y;
    assign w_npos    = 50'(w_pos_sel) + w_dpos;

    always_comb begin
        if (w_npos > 50'(POS_MAX)) begin
            w_pos_sat = POS_MAX;
        end else if (w_npos < 50'(POS_MIN)) begin
            w_pos_sat = POS_MIN;
        end else begin
            w_pos_sat = w_npos[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_prev      <= 48'd0;
            r_x         <= 48'sd0;
            r_y         <= 48'sd0;
            r_head      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_mode <= i_cfg_wr_data;
            if (i_cmd == CMD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (i_cmd)
                CMD_LOAD: begin
                    r_prev      <= w_ts;
                    r_vin       <= i_s_axis_tdata[79:48];
                    r_win       <= i_s_axis_tdata[111:80];
                    r_mode_used <= r_mode;
                    r_dtneg     <= w_dt[31];
                    r_dtm       <= w_dt[31] ? (32'd0 - 32'(w_dt)) : 32'(w_dt);
                end
                CMD_MULW: r_am <= w_prod;
                CMD_MULV: r_dq <= w_prod[62:0];
                CMD_Q0:   r_qacc <= 64'(w_prod[63:28]);
                CMD_Q1, CMD_Q2: r_qacc <= r_qacc + w_prod;
                CMD_Q3:   r_qacc <= 64'(r_qacc[63:28]) + w_prod;
                CMD_KLO:  r_plo <= w_prod;
                CMD_KHI:  r_phi <= w_prod;
                CMD_HEAD: begin
                    r_dth  <= w_dth;
                    r_cang <= r_mode_used ? (r_head + w_half) : r_head;
                end
                CMD_COR_INIT: begin
                    r_cx <= 34'sd652032874;
                    r_cy <= 34'sd0;
                    r_ci <= '0;
                    if (w_z0 > 34'sd1073741824) begin
                        r_cz    <= w_z0 - 34'sd2147483648;
                        r_cflip <= 1'b1;
                    end else if (w_z0 < -34'sd1073741824) begin
                        r_cz    <= w_z0 + 34'sd2147483648;
                        r_cflip <= 1'b1;
                    end else begin
                        r_cz    <= w_z0;
                        r_cflip <= 1'b0;
                    end
                end
                CMD_COR_STEP: begin
                    r_ci <= r_ci + 1'b1;
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - w_at;
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + w_at;
                    end
                end
                CMD_COR1_END: begin
                    r_c1   <= w_cfin;
                    r_s1   <= w_sfin;
                    r_head <= w_head_new;
                    r_cang <= {w_head_new[31], w_head_new[31:1]};
                end
                CMD_COR2_END: begin
                    r_qw <= w_cfin;
                    r_qz <= w_sfin;
                end
                CMD_XA, CMD_YA: r_pa <= w_prod;
                CMD_XB, CMD_YB: r_pb <= w_prod;
                CMD_XUPD: r_x <= w_pos_sat;
                CMD_YUPD: r_y <= w_pos_sat;
                CMD_OUT: begin
                    r_out_data  <= {r_win, r_vin, r_qw, r_qz, r_head, r_y, r_x};
                    r_out_user  <= r_mode_used;
                end
                default: ;
            endcase
        end
    end

    assign o_status.cor_last = (r_ci == C_LAST);
    assign o_status.out_busy = r_out_valid && !i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

FILE: design/planar_odometry_integrator.sv
`timescale 1ns / 1ps
// Planar odometry integrator (unicycle dead reckoning, Euler or midpoint RK2).
// Input stream: one request per velocity sample, tdata carries the time stamp,
// forward speed and yaw rate. Output stream: one request per sample with the
// new pose, yaw quaternion, echoed velocities, and the applied mode in tuser.
// i_cfg_wr_en/i_cfg_wr_data write the integration mode (0 Euler, 1 RK2);
// write it only while the block is idle.
// Work from input accept to o_m_axis_tvalid: products on one shared 32x32
// multiplier, including a four-step reciprocal multiply that turns speed
// times interval into distance, then two serial CORDIC passes, then the x
// and y updates. One sample is in flight at a time; the next is accepted
// only after the previous result is written to the output register, so a
// new sample is never taken before the last one is finished.
// Reset clears pose, heading, previous time stamp and mode; the first
// sample after reset has a zero interval and leaves the pose unchanged.
// If the receiver stalls, the result holds in the output register and one
// more sample is taken and worked on; it then waits until the register
// frees before its result is written.
module planar_odometry_integrator #(
    parameter int CORDIC_STEPS = 24,
    parameter int FRAC_BITS    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // timestamp_us[47:0], linear_velocity[79:48], angular_velocity[111:80]
    input  logic [111:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pos_x[47:0], pos_y[95:48], heading[127:96], quat_z[159:128],
    // quat_w[191:160], linear_velocity_echo[223:192], angular_velocity_echo[255:224]
    output logic [255:0] o_m_axis_tdata,
    // mode_used[0]
    output logic         o_m_axis_tuser
);
    import poi_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    poi_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_status        (w_status),
        .o_s_axis_tready (o_s_axis_tready),
        .o_cmd           (w_cmd)
    );

    poi_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

FILE: sim/planar_odometry_integrator_tb.sv
`timescale 1ns / 1ps
module planar_odometry_integrator_tb;
    import poi_pkg::*;

    typedef struct {
        logic [47:0] px;
        logic [47:0] py;
        logic [31:0] hd;
        logic [31:0] qz;
        logic [31:0] qw;
        logic [31:0] lv;
        logic [31:0] av;
        logic        mode;
    } t_pose;

    localparam longint Q30     = 64'sd1073741824;
    localparam longint POS_MAX = 64'sd140737488355327;
    localparam longint POS_MIN = -64'sd140737488355328;
    localparam longint DT_MAX  = 64'sd2147483647;
    localparam longint DT_MIN  = -64'sd2147483648;
    localparam int     ROT_STEPS = 24;

    localparam logic [31:0] ROT_ATAN [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic         i_cfg_wr_data = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // timestamp_us[47:0], linear_velocity[79:48], angular_velocity[111:80]
    logic [111:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // pos_x, pos_y, heading, quat_z, quat_w, linear echo, angular echo
    logic [255:0] o_m_axis_tdata;
    // mode_used[0]
    logic         o_m_axis_tuser;

    planar_odometry_integrator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    logic [111:0] sample_queue[$];
    t_pose        pose_expected[$];
    int           mismatch_count = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           hold_reqs = 0;
    logic [47:0]  gen_stamp = '0;

    // predictor state
    longint       odo_x = 0;
    longint       odo_y = 0;
    logic [31:0]  odo_heading = '0;
    logic [47:0]  odo_prev_stamp = '0;
    logic         odo_mode = 1'b0;

    function automatic void rotate(input logic [31:0] ang, output longint c,
                                   output longint s);
        longint z, x, y, nx;
        bit     flip;
        z = longint'($signed(ang));
        x = CORDIC_GAIN;
        y = 0;
        flip = 0;
        if (z > Q30) begin
            z -= 2 * Q30;
            flip = 1;
        end else if (z < -Q30) begin
            z += 2 * Q30;
            flip = 1;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= longint'({32'b0, ROT_ATAN[i]});
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += longint'({32'b0, ROT_ATAN[i]});
            end
            x = nx;
        end
        x = (x < -Q30) ? -Q30 : ((x > Q30) ? Q30 : x);
        y = (y < -Q30) ? -Q30 : ((y > Q30) ? Q30 : y);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint scale_q30(input logic [63:0] m, input bit neg,
                                         input longint c);
        logic [63:0]  cm;
        logic [127:0] p;
        longint       r;
        cm = (c < 0) ? 64'(-c) : 64'(c);
        p = m * cm;
        r = longint'(p >> 30);
        return (neg != (c < 0)) ? -r : r;
    endfunction

    function automatic longint sat_pos(input longint v);
        return (v < POS_MIN) ? POS_MIN : ((v > POS_MAX) ? POS_MAX : v);
    endfunction

    function automatic t_pose odometry_step(input logic [111:0] d);
        t_pose        e;
        logic [47:0]  ts;
        longint       v, w, dt, prod, c, s;
        logic [63:0]  am, r, dm;
        logic [127:0] p;
        logic [31:0]  dth, half, phi, hh;
        bit           aneg, dneg;
        ts = d[47:0];
        v = longint'($signed(d[79:48]));
        w = longint'($signed(d[111:80]));
        dt = 0;
        if (odo_prev_stamp != 0) begin
            dt = longint'({16'b0, ts}) - longint'({16'b0, odo_prev_stamp});
            dt = (dt < DT_MIN) ? DT_MIN : ((dt > DT_MAX) ? DT_MAX : dt);
        end
        odo_prev_stamp = ts;

        aneg = (w < 0) != (dt < 0);
        prod = w * dt;
        am = (prod < 0) ? 64'(-prod) : 64'(prod);
        p = am * 128'(DT_ANGLE_K);
        r = 64'(p >> 38);
        dth = aneg ? -r[31:0] : r[31:0];
        half = aneg ? -(r[32:1]) : r[32:1];

        phi = odo_mode ? odo_heading + half : odo_heading;
        rotate(phi, c, s);
        dneg = (v < 0) != (dt < 0);
        prod = v * dt;
        dm = ((prod < 0) ? 64'(-prod) : 64'(prod)) / 64'(DIST_DIV);
        odo_x = sat_pos(odo_x + scale_q30(dm, dneg, c));
        odo_y = sat_pos(odo_y + scale_q30(dm, dneg, s));
        odo_heading += dth;

        hh = 32'($signed(odo_heading) >>> 1);
        rotate(hh, c, s);
        e.px = odo_x[47:0];
        e.py = odo_y[47:0];
        e.hd = odo_heading;
        e.qz = s[31:0];
        e.qw = c[31:0];
        e.lv = d[79:48];
        e.av = d[111:80];
        e.mode = odo_mode;
        return e;
    endfunction

    task automatic report(input string field, input logic [63:0] got,
                          input logic [63:0] want);
        $display("%0t: %s got %h want %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // sender
    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            nv = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pose_expected.push_back(odometry_step(i_s_axis_tdata));
                void'(sample_queue.pop_front());
                nv = 1'b0;
            end
            if (!nv && sample_queue.size() > 0
                    && $urandom_range(99) >= tx_idle_pct) begin
                nv = 1'b1;
                i_s_axis_tdata <= sample_queue[0];
            end
            i_s_axis_tvalid <= nv;
        end
    end

    // receiver and checker
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        t_pose e;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pose_expected.size() == 0) begin
                    report("unexpected result", o_m_axis_tdata[63:0], 64'd0);
                end else begin
                    e = pose_expected.pop_front();
                    if (o_m_axis_tdata[47:0] !== e.px)
                        report("pos_x", 64'(o_m_axis_tdata[47:0]), 64'(e.px));
                    if (o_m_axis_tdata[95:48] !== e.py)
                        report("pos_y", 64'(o_m_axis_tdata[95:48]), 64'(e.py));
                    if (o_m_axis_tdata[127:96] !== e.hd)
                        report("heading", 64'(o_m_axis_tdata[127:96]), 64'(e.hd));
                    if (o_m_axis_tdata[159:128] !== e.qz)
                        report("quat_z", 64'(o_m_axis_tdata[159:128]), 64'(e.qz));
                    if (o_m_axis_tdata[191:160] !== e.qw)
                        report("quat_w", 64'(o_m_axis_tdata[191:160]), 64'(e.qw));
                    if (o_m_axis_tdata[223:192] !== e.lv)
                        report("linear echo", 64'(o_m_axis_tdata[223:192]), 64'(e.lv));
                    if (o_m_axis_tdata[255:224] !== e.av)
                        report("angular echo", 64'(o_m_axis_tdata[255:224]), 64'(e.av));
                    if (o_m_axis_tuser !== e.mode)
                        report("mode_used", 64'(o_m_axis_tuser), 64'(e.mode));
                end
            end
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic push_sample(input logic [47:0] ts, input logic [31:0] v,
                               input logic [31:0] w);
        sample_queue.push_back({w, v, ts});
        gen_stamp = ts;
    endtask

    function automatic logic [31:0] modest(input int bits);
        return 32'($signed({1'b0, $urandom_range((1 << bits) - 1)}) - (1 << (bits - 1)));
    endfunction

    task automatic wait_idle();
        while (sample_queue.size() > 0 || pose_expected.size() > 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        odo_mode = m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic fill_random(input int count);
        int n, kind, len;
        n = 0;
        // position saturation: long run at full speed and maximum interval
        for (int i = 0; i < 50; i++)
            push_sample(gen_stamp + 48'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        n += 50;
        while (n < count) begin
            kind = $urandom_range(9);
            if (kind <= 5) begin
                len = $urandom_range(10, 30);
                for (int i = 0; i < len; i++)
                    push_sample(gen_stamp + 48'($urandom_range(1, 200000)),
                                modest($urandom_range(8, 22)), modest($urandom_range(8, 22)));
                n += len;
            end else if (kind == 6) begin
                push_sample(48'({$urandom, $urandom}), $urandom, $urandom);
                n++;
            end else if (kind == 7) begin
                push_sample(gen_stamp - 48'($urandom_range(1, 3000000)), $urandom, $urandom);
                n++;
            end else if (kind == 8) begin
                push_sample(gen_stamp + {15'b0, $urandom, 1'b0}, $urandom, $urandom);
                n++;
            end else begin
                push_sample(48'h0, modest(20), modest(20));
                push_sample(48'($urandom_range(1, 5000000)), modest(20), modest(20));
                n += 2;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(1'b0);

        tx_idle_pct = 33;
        rx_idle_pct = 63;
        // directed: zero stamps, field extremes, backwards and huge steps
        push_sample(48'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_sample(48'h0, 32'h8000_0000, 32'h8000_0000);
        push_sample(48'd1000, 32'h0001_0000, 32'h0001_0000);
        push_sample(48'd21000, 32'h0001_0000, 32'h0001_0000);
        push_sample(48'd1021000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_sample(48'd2021000, 32'h8000_0000, 32'h8000_0000);
        push_sample(48'd1021000, 32'h0002_0000, 32'hFFFF_0000);
        push_sample(48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        push_sample(48'h0, 32'h0, 32'h0);
        push_sample(48'd5, 32'hFFFF_FFFF, 32'h0000_0001);
        push_sample(48'hFFFF_FFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_sample(48'h0000_0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        push_sample(48'h0000_8000_0000, 32'h0, 32'h0003_243F);
        push_sample(48'h0001_0000_0000, 32'h0100_0000, 32'hFFFC_DBC1);
        push_sample(48'h0001_0001_0000, 32'h5555_5555, 32'hAAAA_AAAA);
        push_sample(48'h0001_0002_0000, 32'hAAAA_AAAA, 32'h5555_5555);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                wait_idle();
                write_mode(ph[0]);
            end
            tx_idle_pct = (ph < 2) ? 33 : ((ph < 4) ? 63 : 0);
            rx_idle_pct = (ph < 2) ? 63 : ((ph < 4) ? 33 : 0);
            fill_random(265);
            if (ph == 4) begin
                repeat (200) @(posedge i_clk);
                hold_reqs++;
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
